@@ design/two_bone_vector_blend_skinning_top_defines.svh @@
// Assertion macros of the skinning block, used by its top level.
// Needs no other file; included by modules that carry assertions.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef TWO_BONE_VECTOR_BLEND_SKINNING_TOP_DEFINES_SVH
`define TWO_BONE_VECTOR_BLEND_SKINNING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TBVBS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tbvbs assertion failed: %m");
`define TBVBS_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tbvbs forbidden condition seen: %m");
`else
`define TBVBS_ASSERT(lbl, clk, rst, prop)
`define TBVBS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ design/tbvbs_pkg.sv @@
// Shared types and constants of the two-bone vector skinning block.
// No dependencies; used by tbvbs_bone_mem and the top level.
`default_nettype none

package tbvbs_pkg;

  localparam int BONE_COUNT    = 256;
  localparam int BONE_W        = $clog2(BONE_COUNT);
  localparam int FRACTION_BITS = 14;
  localparam int FACTOR_BITS   = 15;
  localparam int MAT_ENTRIES   = 9;
  localparam int LANE_W        = 4;

  localparam logic [15:0] ONE_FACTOR = 16'h8000;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_XFORM = 1'b1
  } kind_t;

  typedef logic signed [15:0] comp_t;
  typedef comp_t [MAT_ENTRIES-1:0] mat_t;

  // Single-lane write into one bone's matrix row.
  typedef struct packed {
    logic              en;
    logic [BONE_W-1:0] bone;
    logic [LANE_W-1:0] lane;
    comp_t             value;
  } bone_wr_t;

  // Request payload, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    comp_t       element_value;
    logic [1:0]  matrix_col;
    logic [1:0]  matrix_row;
    comp_t       vec_z;
    comp_t       vec_y;
    comp_t       vec_x;
    logic [15:0] blend_factor;
    logic        has_minor;
    logic [7:0]  aux_bone;
    logic        has_major;
    logic [7:0]  main_bone;
  } in_data_t;

  typedef struct packed {
    comp_t out_z;
    comp_t out_y;
    comp_t out_x;
  } out_data_t;

endpackage

`default_nettype wire

@@ design/two_bone_vector_blend_skinning_top.sv @@
// Two-bone skinning of direction vectors. A store request (tuser = 0) writes
// one Q1.14 entry of a bone's 3x3 rotation matrix and returns nothing; a
// transform request (tuser = 1) returns the vector rotated by its major
// bone, blended with the rotation by its minor bone when one is given and
// the Q1.15 factor is below 1.0, or the vector unchanged when it has no
// major bone. The block takes one request per cycle unless the sink
// stalls a full pipeline. A transform result passes five register levels:
// memory read, products, row sums, blend products, and round and
// saturate. The first is the bone store's synchronous read and the four
// arithmetic stages follow it; each stage holds only while the one after
// it is full, so the pipeline fills its bubbles under backpressure.
// The bone store holds 256 rows of nine entries in two copies, one per
// read port; it needs no clearing pass, and entries read before they were
// written give undefined results. A store is visible to any request
// accepted after it.
`include "two_bone_vector_blend_skinning_top_defines.svh"
`default_nettype none

module two_bone_vector_blend_skinning_top (
  input  wire                   clk,
  input  wire                   rst,
  // Request channel.
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0: main_bone[7:0], has_major[8], aux_bone[16:9],
  // has_minor[17], blend_factor[33:18], vec_x[49:34], vec_y[65:50],
  // vec_z[81:66], matrix_row[83:82], matrix_col[85:84],
  // element_value[101:86], zero fill[103:102].
  input  wire tbvbs_pkg::in_data_t s_tdata,
  // s_tuser, bit 0: kind (0 store a matrix entry, 1 transform a vector).
  input  wire                   s_tuser,
  // Result channel.
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // m_tdata, from bit 0: out_x[15:0], out_y[31:16], out_z[47:32].
  output tbvbs_pkg::out_data_t  m_tdata
);
  import tbvbs_pkg::*;

  // Arithmetic widths. Each product is a full 16x16 signed product; a row
  // sum of three needs two more bits; the blend multiplies by a 17-bit
  // signed weight and the final add needs one more bit.
  localparam int PROD_W  = 32;
  localparam int SUM_W   = PROD_W + 2;
  localparam int WGT_W   = FACTOR_BITS + 2;
  localparam int BLEND_W = SUM_W + WGT_W;
  localparam int ACC_W   = BLEND_W + 1;
  localparam int SHIFT   = FRACTION_BITS + FACTOR_BITS;

  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) <<< (SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

  // Round half up, then saturate to the 16-bit component range.
  function automatic comp_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = (acc + RND) >>> SHIFT;
    if (sh > SAT_MAX) begin
      sh = SAT_MAX;
    end else if (sh < SAT_MIN) begin
      sh = SAT_MIN;
    end
    return sh[15:0];
  endfunction

  // ---------------------------------------------------------------------
  // Pipeline enables. A stage loads when it is empty or its successor
  // loads, so only a full chain stalls the request side.
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en2, en3, en4, en_out;

  always_comb begin
    en_out   = !m_tvalid || m_tready;
    en4      = !v4 || en_out;
    en3      = !v3 || en4;
    en2      = !v2 || en3;
    s_tready = !v1 || en2;
  end

  // ---------------------------------------------------------------------
  // Request decode.
  // ---------------------------------------------------------------------
  logic        accept;
  logic        is_xform;
  logic [15:0] f_sat;
  logic        use_blend;
  logic [15:0] w_in;
  logic        maj_in_range;
  logic        min_in_range;
  logic        row_ok;
  logic        col_ok;
  logic [LANE_W-1:0] lane;
  bone_wr_t    wr;

  always_comb begin
    accept       = s_tvalid && s_tready;
    is_xform     = (s_tuser == KIND_XFORM);
    f_sat        = (s_tdata.blend_factor > ONE_FACTOR) ? ONE_FACTOR : s_tdata.blend_factor;
    use_blend    = s_tdata.has_minor && (f_sat != ONE_FACTOR);
    // Without a blend the major weight is 1.0 and the minor rows read as
    // zero, which reduces the blend to a plain round of the major sum.
    w_in         = use_blend ? f_sat : ONE_FACTOR;
    maj_in_range = 32'(s_tdata.main_bone) < BONE_COUNT;
    min_in_range = 32'(s_tdata.aux_bone) < BONE_COUNT;
    row_ok       = s_tdata.matrix_row < 2'd3;
    col_ok       = s_tdata.matrix_col < 2'd3;
    lane         = ({2'b00, s_tdata.matrix_row} * 4'd3) + {2'b00, s_tdata.matrix_col};

    wr.en    = accept && !is_xform && row_ok && col_ok && maj_in_range;
    wr.bone  = BONE_W'(s_tdata.main_bone);
    wr.lane  = lane;
    wr.value = s_tdata.element_value;
  end

  // ---------------------------------------------------------------------
  // Stage 1: bone rows come out of the store, registered.
  // ---------------------------------------------------------------------
  mat_t rd_maj, rd_min;

  tbvbs_bone_mem u_bone_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (s_tready),
    .rd_a_addr (BONE_W'(s_tdata.main_bone)),
    .rd_b_addr (BONE_W'(s_tdata.aux_bone)),
    .rd_a_data (rd_maj),
    .rd_b_data (rd_min)
  );

  logic        h1_major, ok1_maj, ok1_min;
  logic [15:0] w1;
  out_data_t   pass1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= accept && is_xform;
    end
    if (s_tready) begin
      h1_major <= s_tdata.has_major;
      ok1_maj  <= maj_in_range;
      ok1_min  <= use_blend && min_in_range;
      w1       <= w_in;
      pass1    <= '{out_z: s_tdata.vec_z, out_y: s_tdata.vec_y, out_x: s_tdata.vec_x};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: eighteen 16x16 products.
  // ---------------------------------------------------------------------
  comp_t vec1 [3];
  mat_t  m_maj, m_min;

  always_comb begin
    vec1[0] = pass1.out_x;
    vec1[1] = pass1.out_y;
    vec1[2] = pass1.out_z;
    m_maj   = ok1_maj ? rd_maj : '0;
    m_min   = ok1_min ? rd_min : '0;
  end

  logic signed [PROD_W-1:0] p2_maj [3][3];
  logic signed [PROD_W-1:0] p2_min [3][3];
  logic        h2_major;
  logic [15:0] w2;
  out_data_t   pass2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p2_maj[r][c] <= $signed(vec1[c]) * $signed(m_maj[r*3 + c]);
          p2_min[r][c] <= $signed(vec1[c]) * $signed(m_min[r*3 + c]);
        end
      end
      h2_major <= h1_major;
      w2       <= w1;
      pass2    <= pass1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: row sums.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] s3_maj [3];
  logic signed [SUM_W-1:0] s3_min [3];
  logic        h3_major;
  logic [15:0] w3;
  out_data_t   pass3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        s3_maj[r] <= SUM_W'(p2_maj[r][0]) + SUM_W'(p2_maj[r][1]) + SUM_W'(p2_maj[r][2]);
        s3_min[r] <= SUM_W'(p2_min[r][0]) + SUM_W'(p2_min[r][1]) + SUM_W'(p2_min[r][2]);
      end
      h3_major <= h2_major;
      w3       <= w2;
      pass3    <= pass2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: weight each sum by its blend factor.
  // ---------------------------------------------------------------------
  logic signed [WGT_W-1:0] wgt_maj, wgt_min;

  always_comb begin
    wgt_maj = $signed({1'b0, w3});
    wgt_min = $signed({1'b0, ONE_FACTOR - w3});
  end

  logic signed [BLEND_W-1:0] b4_maj [3];
  logic signed [BLEND_W-1:0] b4_min [3];
  logic      h4_major;
  out_data_t pass4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      for (int r = 0; r < 3; r++) begin
        b4_maj[r] <= s3_maj[r] * wgt_maj;
        b4_min[r] <= s3_min[r] * wgt_min;
      end
      h4_major <= h3_major;
      pass4    <= pass3;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: add, round, saturate, or pass the vector through when
  // the vertex has no major bone.
  // ---------------------------------------------------------------------
  comp_t res [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      res[r] = round_sat(ACC_W'(b4_maj[r]) + ACC_W'(b4_min[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v4;
    end
    if (en_out) begin
      if (h4_major) begin
        m_tdata <= '{out_z: res[2], out_y: res[1], out_x: res[0]};
      end else begin
        m_tdata <= pass4;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `TBVBS_ASSERT(a_store_no_result, clk, rst, (accept && !is_xform) |=> !v1)
  `TBVBS_ASSERT_NEVER(a_stall_only_full, clk, rst, !s_tready && !(v1 && v2 && v3 && v4 && m_tvalid))
  `TBVBS_ASSERT(a_pass_through, clk, rst, (v4 && en_out && !h4_major) |=> (m_tvalid && m_tdata == $past(pass4)))
  `TBVBS_ASSERT(a_empty_after_reset, clk, rst, $past(rst) |-> (!m_tvalid && !v1 && !v4))

endmodule

`default_nettype wire

@@ design/tbvbs_bone_mem.sv @@
// Bone rotation store: one row of nine matrix entries per bone, kept in two
// identical copies so the major and minor bones read in the same cycle.
// Depends on tbvbs_pkg.
`default_nettype none

module tbvbs_bone_mem (
  input  wire                             clk,
  input  wire tbvbs_pkg::bone_wr_t        wr,
  input  wire                             rd_en,
  input  wire  [tbvbs_pkg::BONE_W-1:0]    rd_a_addr,
  input  wire  [tbvbs_pkg::BONE_W-1:0]    rd_b_addr,
  output tbvbs_pkg::mat_t                 rd_a_data,
  output tbvbs_pkg::mat_t                 rd_b_data
);
  import tbvbs_pkg::*;

  mat_t mem_a [BONE_COUNT];
  mat_t mem_b [BONE_COUNT];

  // Writes touch a single lane of a row; both copies take every write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.bone][wr.lane] <= wr.value;
      mem_b[wr.bone][wr.lane] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data <= mem_a[rd_a_addr];
      rd_b_data <= mem_b[rd_b_addr];
    end
  end

endmodule

`default_nettype wire
